/* src/hse_pkg.sv */
// types, microcode encoding and control program of the heap sort engine
package hse_pkg;

   localparam int VALUE_W = 32;
   localparam int STEP_W  = 5;

   typedef enum logic [2:0] {
      RD_ZERO,
      RD_NODE,
      RD_LEFT,
      RD_RIGHT,
      RD_K
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_NODE_VBIG,
      WR_BIG_VNODE,
      WR_ZERO_RD,
      WR_K_VNODE
   } wr_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_BUILD_STEP,
      OP_LOAD_NODE,
      OP_START_LOOP,
      OP_CMP_LEFT,
      OP_CMP_RIGHT,
      OP_DESCEND,
      OP_K_DEC,
      OP_SWAP_DONE,
      OP_X_INIT,
      OP_M_INIT,
      OP_M_OUT,
      OP_DONE
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_LEFT,
      C_NO_RIGHT,
      C_BIG_IS_NODE,
      C_K_ZERO,
      C_BUILD,
      C_MORE
   } cond_type;

   typedef struct packed {
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      op_type     op;
   } ctl_type;

   typedef struct packed {
      logic k_zero;
      logic no_left;
      logic no_right;
      logic big_is_node;
      logic build;
      logic out_last;
   } sts_type;

   typedef struct packed {
      logic               valid;
      logic               last;
      logic               overflow;
      logic [VALUE_W-1:0] value;
   } emit_type;

   typedef struct packed {
      rd_sel_type        rd_sel;
      wr_sel_type        wr_sel;
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   localparam logic [STEP_W-1:0] S_B_TEST = 5'd0;
   localparam logic [STEP_W-1:0] S_E0     = 5'd1;
   localparam logic [STEP_W-1:0] S_E1     = 5'd2;
   localparam logic [STEP_W-1:0] S_L0     = 5'd3;
   localparam logic [STEP_W-1:0] S_L1     = 5'd4;
   localparam logic [STEP_W-1:0] S_L2     = 5'd5;
   localparam logic [STEP_W-1:0] S_L3     = 5'd6;
   localparam logic [STEP_W-1:0] S_L4     = 5'd7;
   localparam logic [STEP_W-1:0] S_RET    = 5'd8;
   localparam logic [STEP_W-1:0] S_X_DEC  = 5'd9;
   localparam logic [STEP_W-1:0] S_X_TEST = 5'd10;
   localparam logic [STEP_W-1:0] S_X_RD   = 5'd11;
   localparam logic [STEP_W-1:0] S_X_W0   = 5'd12;
   localparam logic [STEP_W-1:0] S_X_WK   = 5'd13;
   localparam logic [STEP_W-1:0] S_X_INIT = 5'd14;
   localparam logic [STEP_W-1:0] S_M_INIT = 5'd15;
   localparam logic [STEP_W-1:0] S_M_RD   = 5'd16;
   localparam logic [STEP_W-1:0] S_M_OUT  = 5'd17;
   localparam logic [STEP_W-1:0] S_DONE   = 5'd18;

   function automatic ucode_type ucode(input logic [STEP_W-1:0] s);
      ucode_type u;
      case (s)
         // heap build: sift down from the middle toward the root
         S_B_TEST: u = '{RD_ZERO,  WR_NONE,      OP_BUILD_STEP, C_K_ZERO,      S_X_INIT};
         // sift down routine
         S_E0:     u = '{RD_NODE,  WR_NONE,      OP_NONE,       C_NEVER,       S_E0};
         S_E1:     u = '{RD_ZERO,  WR_NONE,      OP_LOAD_NODE,  C_NEVER,       S_E0};
         S_L0:     u = '{RD_LEFT,  WR_NONE,      OP_START_LOOP, C_NO_LEFT,     S_RET};
         S_L1:     u = '{RD_RIGHT, WR_NONE,      OP_CMP_LEFT,   C_NO_RIGHT,    S_L3};
         S_L2:     u = '{RD_ZERO,  WR_NONE,      OP_CMP_RIGHT,  C_NEVER,       S_L0};
         S_L3:     u = '{RD_ZERO,  WR_NODE_VBIG, OP_NONE,       C_BIG_IS_NODE, S_RET};
         S_L4:     u = '{RD_ZERO,  WR_BIG_VNODE, OP_DESCEND,    C_ALWAYS,      S_L0};
         S_RET:    u = '{RD_ZERO,  WR_NONE,      OP_NONE,       C_BUILD,       S_B_TEST};
         // extraction: swap root with heap end, shrink, sift
         S_X_DEC:  u = '{RD_ZERO,  WR_NONE,      OP_K_DEC,      C_NEVER,       S_X_DEC};
         S_X_TEST: u = '{RD_ZERO,  WR_NONE,      OP_NONE,       C_K_ZERO,      S_M_INIT};
         S_X_RD:   u = '{RD_K,     WR_NONE,      OP_LOAD_NODE,  C_NEVER,       S_X_RD};
         S_X_W0:   u = '{RD_ZERO,  WR_ZERO_RD,   OP_NONE,       C_NEVER,       S_X_W0};
         S_X_WK:   u = '{RD_ZERO,  WR_K_VNODE,   OP_SWAP_DONE,  C_ALWAYS,      S_E0};
         S_X_INIT: u = '{RD_ZERO,  WR_NONE,      OP_X_INIT,     C_ALWAYS,      S_X_TEST};
         // output sweep
         S_M_INIT: u = '{RD_ZERO,  WR_NONE,      OP_M_INIT,     C_NEVER,       S_M_INIT};
         S_M_RD:   u = '{RD_K,     WR_NONE,      OP_NONE,       C_NEVER,       S_M_RD};
         S_M_OUT:  u = '{RD_ZERO,  WR_NONE,      OP_M_OUT,      C_MORE,        S_M_RD};
         S_DONE:   u = '{RD_ZERO,  WR_NONE,      OP_DONE,       C_NEVER,       S_DONE};
         default:  u = '{RD_ZERO,  WR_NONE,      OP_DONE,       C_NEVER,       S_DONE};
      endcase
      return u;
   endfunction

endpackage

/* src/hse_ram.sv */
// generic single-write, single-read ram with registered read data
module hse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/hse_seq.sv */
// microcode sequencer: step counter, control rom and conditional jumps
module hse_seq
   import hse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    go,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    busy
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              running_ff, running_in;
   ucode_type         uw;
   logic              take;

   always_comb begin
      uw = ucode(step_ff);
      case (uw.cond)
         C_NEVER:       take = 1'b0;
         C_ALWAYS:      take = 1'b1;
         C_NO_LEFT:     take = sts.no_left;
         C_NO_RIGHT:    take = sts.no_right;
         C_BIG_IS_NODE: take = sts.big_is_node;
         C_K_ZERO:      take = sts.k_zero;
         C_BUILD:       take = sts.build;
         C_MORE:        take = ~sts.out_last;
         default:       take = 1'b0;
      endcase

      step_in    = step_ff;
      running_in = running_ff;
      if (go) begin
         step_in    = S_B_TEST;
         running_in = 1'b1;
      end else if (running_ff) begin
         step_in = take ? uw.target : step_ff + 1'b1;
         if (uw.op == OP_DONE) begin
            running_in = 1'b0;
         end
      end

      if (running_ff) begin
         ctl = '{uw.rd_sel, uw.wr_sel, uw.op};
      end else begin
         ctl = '{RD_ZERO, WR_NONE, OP_NONE};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= S_B_TEST;
         running_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         running_ff <= running_in;
      end
   end

   assign busy = running_ff;

endmodule

/* src/hse_dp.sv */
// datapath: element store, heap index and value registers, load path
module hse_dp
   import hse_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic signed [VALUE_W-1:0] value,
   input  logic                      last,
   input  ctl_type                   ctl,
   output sts_type                   sts,
   output emit_type                  emit
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CH_W   = CNT_W + 1;

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      drop_ff, drop_in;
   logic [CNT_W-1:0]          size_ff, size_in;
   logic [CNT_W-1:0]          k_ff, k_in;
   logic [ADDR_W-1:0]         node_ff, node_in;
   logic [ADDR_W-1:0]         big_ff, big_in;
   logic signed [VALUE_W-1:0] vnode_ff, vnode_in;
   logic signed [VALUE_W-1:0] vbig_ff, vbig_in;
   logic                      phase_ff, phase_in;

   logic                      full;
   logic [CNT_W-1:0]          cnt_next;
   logic [CH_W-1:0]           left;
   logic [CH_W-1:0]           right;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [VALUE_W-1:0]        wr_data;
   logic [ADDR_W-1:0]         rd_addr;
   logic [VALUE_W-1:0]        rd_raw;
   logic signed [VALUE_W-1:0] rd_data;
   logic                      rd_gt;

   hse_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_data  = $signed(rd_raw);
   assign rd_gt    = rd_data > vbig_ff;
   assign full     = cnt_ff == CNT_W'(DEPTH);
   assign cnt_next = full ? cnt_ff : cnt_ff + 1'b1;
   assign left     = CH_W'({node_ff, 1'b1});
   assign right    = left + 1'b1;

   always_comb begin
      sts.k_zero      = k_ff == '0;
      sts.no_left     = left >= CH_W'(size_ff);
      sts.no_right    = right >= CH_W'(size_ff);
      sts.big_is_node = big_ff == node_ff;
      sts.build       = phase_ff;
      sts.out_last    = (k_ff + 1'b1) == cnt_ff;
   end

   always_comb begin
      case (ctl.rd_sel)
         RD_ZERO:  rd_addr = '0;
         RD_NODE:  rd_addr = node_ff;
         RD_LEFT:  rd_addr = left[ADDR_W-1:0];
         RD_RIGHT: rd_addr = right[ADDR_W-1:0];
         RD_K:     rd_addr = k_ff[ADDR_W-1:0];
         default:  rd_addr = '0;
      endcase

      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = vnode_ff;
      if (accept && !full) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff[ADDR_W-1:0];
         wr_data = value;
      end else begin
         case (ctl.wr_sel)
            WR_NONE: begin
               wr_en = 1'b0;
            end
            WR_NODE_VBIG: begin
               wr_en   = 1'b1;
               wr_addr = node_ff;
               wr_data = vbig_ff;
            end
            WR_BIG_VNODE: begin
               wr_en   = 1'b1;
               wr_addr = big_ff;
               wr_data = vnode_ff;
            end
            WR_ZERO_RD: begin
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_data = rd_data;
            end
            WR_K_VNODE: begin
               wr_en   = 1'b1;
               wr_addr = k_ff[ADDR_W-1:0];
               wr_data = vnode_ff;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cnt_in   = cnt_ff;
      drop_in  = drop_ff;
      size_in  = size_ff;
      k_in     = k_ff;
      node_in  = node_ff;
      big_in   = big_ff;
      vnode_in = vnode_ff;
      vbig_in  = vbig_ff;
      phase_in = phase_ff;

      if (accept) begin
         cnt_in  = cnt_next;
         drop_in = drop_ff | full;
         if (last) begin
            size_in  = cnt_next;
            k_in     = cnt_next >> 1;
            phase_in = 1'b1;
         end
      end

      case (ctl.op)
         OP_NONE: begin
         end
         OP_BUILD_STEP: begin
            k_in    = k_ff - 1'b1;
            node_in = ADDR_W'(k_ff - 1'b1);
         end
         OP_LOAD_NODE: begin
            vnode_in = rd_data;
         end
         OP_START_LOOP: begin
            big_in  = node_ff;
            vbig_in = vnode_ff;
         end
         OP_CMP_LEFT: begin
            if (rd_gt) begin
               big_in  = left[ADDR_W-1:0];
               vbig_in = rd_data;
            end
         end
         OP_CMP_RIGHT: begin
            if (rd_gt) begin
               big_in  = right[ADDR_W-1:0];
               vbig_in = rd_data;
            end
         end
         OP_DESCEND: begin
            node_in = big_ff;
         end
         OP_K_DEC: begin
            k_in = k_ff - 1'b1;
         end
         OP_SWAP_DONE: begin
            size_in = k_ff;
            node_in = '0;
         end
         OP_X_INIT: begin
            k_in     = size_ff - 1'b1;
            phase_in = 1'b0;
         end
         OP_M_INIT: begin
            k_in = '0;
         end
         OP_M_OUT: begin
            k_in = k_ff + 1'b1;
         end
         OP_DONE: begin
            cnt_in  = '0;
            drop_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      emit.valid    = ctl.op == OP_M_OUT;
      emit.last     = sts.out_last;
      emit.overflow = drop_ff;
      emit.value    = rd_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         drop_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         drop_ff <= drop_in;
      end
      size_ff  <= size_in;
      k_ff     <= k_in;
      node_ff  <= node_in;
      big_ff   <= big_in;
      vnode_ff <= vnode_in;
      vbig_ff  <= vbig_in;
      phase_ff <= phase_in;
   end

endmodule

/* src/heap_sort_engine.sv */
// heap sort engine top level: request decode, sequencer, datapath, result registers
//
// a request is taken at a rising clock edge with start high and busy low. each
// request writes req_value into the next free store entry; once DEPTH entries
// are held further values are dropped and the run is marked as overflowed.
// a request with req_last high closes the set: busy rises on the next cycle
// and stays high until the whole set has been emitted.
// while busy is low, loading takes one request per cycle. the sort runs from a
// microcode rom over one store with a single write and a single read port:
// each sift-down level reads the children, compares and makes two writes,
// and each swap of the extraction reads and rewrites the root and heap end.
// results follow as rsp_valid strobes, one per held value, ascending,
// rsp_last_out on the final one and rsp_overflow on all of them if values
// were dropped. results cannot be held off. busy falls in the cycle after the
// final result strobe, with the store empty for the next set.
// reset clears the held count, the overflow mark and the sequencer.
module heap_sort_engine
   import hse_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_sorted_value,
   output logic                      rsp_last_out,
   output logic                      rsp_overflow
);

   logic     accept;
   logic     go;
   ctl_type  ctl;
   sts_type  sts;
   emit_type emit;

   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;
   logic                      rsp_overflow_ff;

   assign accept = start & ~busy;
   assign go     = accept & req_last;

   hse_seq u_seq (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy)
   );

   hse_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .value  (req_value),
      .last   (req_last),
      .ctl    (ctl),
      .sts    (sts),
      .emit   (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit.valid;
      end
      rsp_value_ff    <= $signed(emit.value);
      rsp_last_ff     <= emit.last;
      rsp_overflow_ff <= emit.overflow;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_overflow_ff;

endmodule

/* tb/tb_heap_sort_engine.sv */
// self-checking testbench for heap_sort_engine: directed and random sets, heap sort prediction, result compare
module tb_heap_sort_engine
   import hse_pkg::*;
;

   localparam int DEPTH        = 64;
   localparam int RANDOM_ITEMS = 440;
   localparam int CALM_TAIL    = 60;
   localparam int STALL_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 20;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      drain;
   } request_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last_out;
      logic                      overflow;
   } sorted_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_last = 1'b0;
   logic                      busy;
   logic                      rsp_valid;
   logic signed [VALUE_W-1:0] rsp_sorted_value;
   logic                      rsp_last_out;
   logic                      rsp_overflow;

   request_type pending_q[$];
   sorted_type  sorted_q[$];

   logic signed [VALUE_W-1:0] set_vals [DEPTH];
   int set_count;
   logic set_dropped;

   int gap_left;
   int stall_cycles;
   int mismatches;
   int requests_taken;
   int sets_closed;
   int overflow_sets;
   int results_seen;
   int random_items;
   int set_index;

   heap_sort_engine #(.DEPTH(DEPTH)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   always #4 clock = ~clock;

   task automatic add_request(input logic signed [VALUE_W-1:0] v, input logic lst,
                              input logic drn);
      request_type r;
      r.value = v;
      r.last  = lst;
      r.drain = drn;
      pending_q.push_back(r);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = 32'sh7fffffff;
               1: v = 32'sh80000000;
               2: v = 32'sh00000000;
               3: v = 32'shffffffff;
               default: v = 32'sh00000001;
            endcase
         end
         1, 2: v = $signed($urandom_range(0, 7)) - 4;
         default: v = $urandom();
      endcase
      return v;
   endfunction

   task automatic sift_set(input int size, input int root);
      int node;
      int big;
      int kid;
      logic done;
      logic signed [VALUE_W-1:0] tmp;
      node = root;
      done = 1'b0;
      while (!done) begin
         big = node;
         kid = 2 * node + 1;
         if (kid < size && set_vals[kid] > set_vals[big]) big = kid;
         if (kid + 1 < size && set_vals[kid + 1] > set_vals[big]) big = kid + 1;
         if (big == node) begin
            done = 1'b1;
         end else begin
            tmp = set_vals[node];
            set_vals[node] = set_vals[big];
            set_vals[big] = tmp;
            node = big;
         end
      end
   endtask

   task automatic sort_set(input int n);
      int k;
      logic signed [VALUE_W-1:0] tmp;
      for (k = n / 2; k > 0; k--) sift_set(n, k - 1);
      for (k = n - 1; k > 0; k--) begin
         tmp = set_vals[0];
         set_vals[0] = set_vals[k];
         set_vals[k] = tmp;
         sift_set(k, 0);
      end
   endtask

   task automatic take_request(input logic signed [VALUE_W-1:0] v, input logic lst);
      sorted_type s;
      int k;
      if (set_count < DEPTH) begin
         set_vals[set_count] = v;
         set_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (lst) begin
         sort_set(set_count);
         for (k = 0; k < set_count; k++) begin
            s.value    = set_vals[k];
            s.last_out = (k == set_count - 1);
            s.overflow = set_dropped;
            sorted_q.push_back(s);
         end
         sets_closed++;
         if (set_dropped) overflow_sets++;
         set_count = 0;
         set_dropped = 1'b0;
      end
   endtask

   // driver
   always @(posedge clock) begin
      request_type nxt;
      logic go;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (!(start && busy)) begin
         go = 1'b0;
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_q.size() != 0 &&
                      (!pending_q[0].drain ||
                       (sorted_q.size() == 0 && !start && !rsp_valid))) begin
            nxt = pending_q.pop_front();
            req_value <= nxt.value;
            req_last <= nxt.last;
            go = 1'b1;
            if (pending_q.size() > CALM_TAIL && (pending_q.size() / 50) % 2 == 0 &&
                $urandom_range(0, 4) == 0)
               gap_left <= $urandom_range(1, 11);
         end
         start <= go;
      end
   end

   // monitor and prediction
   always @(posedge clock) begin
      sorted_type want;
      if (reset) begin
         set_count = 0;
         set_dropped = 1'b0;
         stall_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            results_seen++;
            if (sorted_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected result: value %0d last %b overflow %b",
                           rsp_sorted_value, rsp_last_out, rsp_overflow);
            end else begin
               want = sorted_q.pop_front();
               if (rsp_sorted_value !== want.value || rsp_last_out !== want.last_out ||
                   rsp_overflow !== want.overflow) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("mismatch: expected value %0d last %b overflow %b, got %0d %b %b",
                              want.value, want.last_out, want.overflow,
                              rsp_sorted_value, rsp_last_out, rsp_overflow);
               end
            end
         end
         if (start && !busy) begin
            requests_taken++;
            take_request(req_value, req_last);
         end
         if (rsp_valid || (start && !busy)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int n;
      int k;
      // single value, two values, extremes with duplicates, ordered run, all equal
      add_request(32'sh80000000, 1'b1, 1'b0);
      add_request(32'sh7fffffff, 1'b0, 1'b0);
      add_request(32'sh80000000, 1'b1, 1'b0);
      add_request(5, 1'b0, 1'b0);
      add_request(-1, 1'b0, 1'b0);
      add_request(0, 1'b0, 1'b0);
      add_request(32'sh7fffffff, 1'b0, 1'b0);
      add_request(5, 1'b0, 1'b0);
      add_request(32'sh80000000, 1'b0, 1'b0);
      add_request(1, 1'b0, 1'b0);
      add_request(-1, 1'b0, 1'b0);
      add_request(0, 1'b1, 1'b0);
      for (k = -3; k <= 2; k++) add_request(k, k == 2, 1'b0);
      for (k = 0; k < 4; k++) add_request(-1, k == 3, 1'b0);

      random_items = 0;
      set_index = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (set_index == 0) n = DEPTH + 1;
         else if (set_index == 1) n = DEPTH;
         else begin
            case ($urandom_range(0, 19))
               0, 1, 2:  n = $urandom_range(13, 40);
               3, 4:     n = $urandom_range(DEPTH - 4, DEPTH);
               5:        n = $urandom_range(DEPTH + 1, DEPTH + 8);
               default:  n = $urandom_range(1, 12);
            endcase
         end
         for (k = 0; k < n; k++)
            add_request(pick_value(), k == n - 1, k == 0 && set_index % 8 == 0);
         random_items += n;
         set_index++;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (pending_q.size() != 0 || start) @(posedge clock);
      while (sorted_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests in %0d sets, %0d of them with dropped values",
               requests_taken, sets_closed, overflow_sets);
      $display("checked %0d sorted values, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0 && sorted_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
